// File: rtl/wtr_pkg.sv
// Shared constants and helpers for the window tile residency block.
package wtr_pkg;

  // Resident set storage and window geometry.
  localparam int CAPACITY   = 128;
  localparam int MAX_RADIUS = 3;
  localparam int WIN        = 2 * MAX_RADIUS + 1;

  // Field and counter widths.
  localparam int COORD_W    = 16;
  localparam int KEY_W      = 2 * COORD_W;
  localparam int LIMIT_W    = 8;
  localparam int RADIUS_W   = 2;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = $clog2(WIN);
  localparam int CMP_W      = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = CFG_IDX_W'(1);

  // Reset values of the configuration registers.
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = LIMIT_W'(128);
  localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(3);

  // Step a circular buffer address by one slot.
  function automatic logic [ADDR_W-1:0] addr_inc(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] r;
    if (a == ADDR_W'(CAPACITY - 1)) begin
      r = '0;
    end else begin
      r = a + ADDR_W'(1);
    end
    return r;
  endfunction

endpackage

// File: rtl/wtr_ram.sv
// Generic single write port, single read port RAM with registered read data.
module wtr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/window_tile_residency_fifo.sv
// Window tile residency tracker with a FIFO resident set held in RAM.
//
//   channel   direction  handshake                    payload
//   command   in         start_i, busy_o              center_x_i, center_y_i
//   result    out        result_valid_o (strobe)      load, evict, last_of_run
//   config    in         cfg_valid_i, cfg_ready_o     cfg_index_i, cfg_data_i
//
// A command first reads every resident entry once from the RAM, one per cycle, to
// mark which window positions are already resident, then walks the window
// positions in scan order: a resident position is passed over, and a new one
// takes an eviction read, then the result and write-back.
// Reset clears the pointers and count; the RAM content needs no clearing.
// Results are strobed for one cycle; the receiver cannot stall them.
module window_tile_residency_fifo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [wtr_pkg::COORD_W-1:0]  center_x_i,
  input  logic signed [wtr_pkg::COORD_W-1:0]  center_y_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wtr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [wtr_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                result_valid_o,
  output logic signed [wtr_pkg::COORD_W-1:0]  load_x_o,
  output logic signed [wtr_pkg::COORD_W-1:0]  load_y_o,
  output logic                                evict_valid_o,
  output logic signed [wtr_pkg::COORD_W-1:0]  evict_x_o,
  output logic signed [wtr_pkg::COORD_W-1:0]  evict_y_o,
  output logic                                last_of_run_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_POS  = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  localparam int CW = wtr_pkg::COORD_W;
  localparam int PW = wtr_pkg::POS_W;
  localparam int AW = wtr_pkg::ADDR_W;
  localparam int NW = wtr_pkg::CNT_W;
  localparam int WN = wtr_pkg::WIN;

  // Control state.
  logic [1:0]                     state_q, state_d;
  logic [AW-1:0]                  head_q, head_d;
  logic [AW-1:0]                  tail_q, tail_d;
  logic [NW-1:0]                  count_q, count_d;
  logic [wtr_pkg::LIMIT_W-1:0]    limit_q;
  logic [wtr_pkg::RADIUS_W-1:0]   radius_q;
  logic                           cmp_vld_q, cmp_vld_d;
  logic [WN-1:0][WN-1:0]          todo_q, todo_d;

  // Per-command working registers.
  logic [CW-1:0]                  cx_q, cx_d;
  logic [CW-1:0]                  cy_q, cy_d;
  logic [wtr_pkg::RADIUS_W-1:0]   r_q, r_d;
  logic [NW-1:0]                  lim_q, lim_d;
  logic [PW-1:0]                  i_q, i_d;
  logic [PW-1:0]                  j_q, j_d;
  logic [AW-1:0]                  scan_addr_q, scan_addr_d;
  logic [NW-1:0]                  scan_left_q, scan_left_d;

  // RAM port signals.
  logic                           ram_we;
  logic                           ram_re;
  logic [AW-1:0]                  ram_raddr;
  logic [wtr_pkg::KEY_W-1:0]      ram_rdata;

  logic [wtr_pkg::RADIUS_W-1:0]   r_sat;
  logic [PW-1:0]                  two_r;
  logic [CW-1:0]                  two_r_w;
  logic [CW-1:0]                  pos_x, pos_y;
  logic [wtr_pkg::KEY_W-1:0]      pos_key;
  logic [CW-1:0]                  dx, dy;
  logic                           in_win;
  logic                           evict;
  logic [wtr_pkg::KEY_W-1:0]      evict_key;
  logic [WN-1:0][WN-1:0]          todo_clr;
  logic                           accept;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign r_sat   = (radius_q > wtr_pkg::RADIUS_W'(wtr_pkg::MAX_RADIUS)) ?
                   wtr_pkg::RADIUS_W'(wtr_pkg::MAX_RADIUS) : radius_q;
  assign two_r   = PW'({r_q, 1'b0});
  assign two_r_w = CW'({r_q, 1'b0});

  // Current window position in wrapped tile coordinates.
  assign pos_x   = cx_q + CW'(i_q) - CW'(r_q);
  assign pos_y   = cy_q + CW'(j_q) - CW'(r_q);
  assign pos_key = {pos_x, pos_y};

  // Offset of a stored entry from the window corner.
  assign dx     = ram_rdata[wtr_pkg::KEY_W-1:CW] - cx_q + CW'(r_q);
  assign dy     = ram_rdata[CW-1:0] - cy_q + CW'(r_q);
  assign in_win = (dx <= two_r_w) && (dy <= two_r_w);

  // The new word pushes out the oldest when the set is already at its limit.
  // With an empty set that oldest is the new word itself.
  assign evict     = (count_q >= lim_q);
  assign evict_key = (count_q == '0) ? pos_key : ram_rdata;

  always_comb begin
    todo_clr = todo_q;
    todo_clr[i_q][j_q] = 1'b0;
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    cmp_vld_d   = 1'b0;
    todo_d      = todo_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    r_d         = r_q;
    lim_d       = lim_q;
    i_d         = i_q;
    j_d         = j_q;
    scan_addr_d = scan_addr_q;
    scan_left_d = scan_left_q;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = head_q;

    if (cmp_vld_q && in_win) begin
      todo_d[dx[PW-1:0]][dy[PW-1:0]] = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d     = ST_SCAN;
          cx_d        = $unsigned(center_x_i);
          cy_d        = $unsigned(center_y_i);
          r_d         = r_sat;
          lim_d       = (wtr_pkg::CMP_W'(limit_q) > wtr_pkg::CMP_W'(wtr_pkg::CAPACITY)) ?
                        NW'(wtr_pkg::CAPACITY) : NW'(limit_q);
          i_d         = '0;
          j_d         = '0;
          scan_addr_d = head_q;
          scan_left_d = count_q;
          for (int a = 0; a < WN; a++) begin
            for (int b = 0; b < WN; b++) begin
              todo_d[a][b] = (a <= 2 * int'(r_sat)) && (b <= 2 * int'(r_sat));
            end
          end
        end
      end
      ST_SCAN: begin
        ram_raddr = scan_addr_q;
        if (scan_left_q != '0) begin
          ram_re      = 1'b1;
          cmp_vld_d   = 1'b1;
          scan_addr_d = wtr_pkg::addr_inc(scan_addr_q);
          scan_left_d = scan_left_q - NW'(1);
        end else if (!cmp_vld_q) begin
          state_d = ST_POS;
        end
      end
      ST_POS: begin
        if (todo_q == '0) begin
          state_d = ST_IDLE;
        end else if (todo_q[i_q][j_q]) begin
          ram_re  = 1'b1;
          state_d = ST_RESP;
        end else if (j_q == two_r) begin
          j_d = '0;
          i_d = i_q + PW'(1);
        end else begin
          j_d = j_q + PW'(1);
        end
      end
      ST_RESP: begin
        ram_we = 1'b1;
        todo_d = todo_clr;
        tail_d = wtr_pkg::addr_inc(tail_q);
        if (evict) begin
          head_d = wtr_pkg::addr_inc(head_q);
        end else begin
          count_d = count_q + NW'(1);
        end
        if (j_q == two_r) begin
          j_d = '0;
          i_d = i_q + PW'(1);
        end else begin
          j_d = j_q + PW'(1);
        end
        state_d = ST_POS;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      cmp_vld_q <= 1'b0;
      todo_q    <= '0;
      limit_q   <= wtr_pkg::LIMIT_RST;
      radius_q  <= wtr_pkg::RADIUS_RST;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      cmp_vld_q <= cmp_vld_d;
      todo_q    <= todo_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          wtr_pkg::CFG_LIMIT: begin
            limit_q <= cfg_data_i[wtr_pkg::LIMIT_W-1:0];
          end
          wtr_pkg::CFG_RADIUS: begin
            radius_q <= cfg_data_i[wtr_pkg::RADIUS_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q        <= cx_d;
    cy_q        <= cy_d;
    r_q         <= r_d;
    lim_q       <= lim_d;
    i_q         <= i_d;
    j_q         <= j_d;
    scan_addr_q <= scan_addr_d;
    scan_left_q <= scan_left_d;
  end

  wtr_ram #(
    .WIDTH (wtr_pkg::KEY_W),
    .DEPTH (wtr_pkg::CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (pos_key),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign result_valid_o = (state_q == ST_RESP);
  assign load_x_o       = $signed(pos_x);
  assign load_y_o       = $signed(pos_y);
  assign evict_valid_o  = result_valid_o && evict;
  assign evict_x_o      = evict_valid_o ? $signed(evict_key[wtr_pkg::KEY_W-1:CW]) : '0;
  assign evict_y_o      = evict_valid_o ? $signed(evict_key[CW-1:0]) : '0;
  assign last_of_run_o  = result_valid_o && (todo_clr == '0);

  // The tail always sits count words past the head, around the ring.
  logic [AW:0] tail_ref_sum;
  logic [AW-1:0] tail_ref;
  assign tail_ref_sum = {1'b0, head_q} + (AW + 1)'(count_q);
  assign tail_ref = (tail_ref_sum >= (AW + 1)'(wtr_pkg::CAPACITY)) ?
                    AW'(tail_ref_sum - (AW + 1)'(wtr_pkg::CAPACITY)) : AW'(tail_ref_sum);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NW'(wtr_pkg::CAPACITY))
    else $error("resident count above capacity");

  a_ring_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q == tail_ref)
    else $error("tail pointer out of step with head and count");

  a_result_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("results strobed on consecutive cycles");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o && !result_valid_o)
    else $error("accepted command did not start a scan");

  a_evict_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && evict_valid_o |=> count_q == $past(count_q))
    else $error("eviction changed the resident count");

endmodule
